// File: design/ghc_pkg.sv
// Shared types, constants and helper functions of the grey-level histogram block.
package ghc_pkg;

    // Number of bins and width of each count and running sum.
    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;

    // Derived widths.
    localparam int BIN_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int WIDE_BITS  = (BIN_BITS > 8) ? BIN_BITS : 8;
    localparam int FIELD_BITS = 8;
    localparam int IN_BITS    = 24;
    localparam int OUT_BITS   = ((2 * COUNT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(BIN_COUNT - 1);

    // Operation codes carried in the lowest bits of the input data.
    typedef enum logic [1:0]
    {
        OP_CLEAR = 2'd0,
        OP_COUNT = 2'd1,
        OP_BUILD = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // One access to a store: clear, registered read and write.
    typedef struct packed
    {
        logic                  clr;
        logic                  rd_en;
        logic [BIN_BITS-1:0]   rd_addr;
        logic                  wr_en;
        logic [BIN_BITS-1:0]   wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
    } store_req_t;

    // Bin address taken from an 8-bit field.
    function automatic logic [BIN_BITS-1:0] bin_addr(input logic [FIELD_BITS-1:0] v);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(v);
        return wide[BIN_BITS-1:0];
    endfunction

    // True when an 8-bit field names an existing bin.
    function automatic logic bin_in_range(input logic [FIELD_BITS-1:0] v);
        return 32'(v) < 32'(BIN_COUNT);
    endfunction

endpackage

// File: design/ghc_store.sv
// One bin store: a synchronous memory with per-entry valid bits and a clear that drops them all at once.
module ghc_store
    import ghc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_req_t            req,
    output logic [COUNT_BITS-1:0] rd_data
);

    logic [COUNT_BITS-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    // Memory array: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Valid bits: an entry never written since reset or clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/ghc_build.sv
// Sequencer that walks every bin once and writes the saturated running sums.
module ghc_build
    import ghc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] cnt_rd_data,
    output logic                  busy,
    output store_req_t            cnt_req,
    output store_req_t            sum_req
);

    typedef enum logic [1:0]
    {
        BLD_IDLE = 2'b01,
        BLD_RUN  = 2'b10
    } bld_state_t;

    bld_state_t            state_reg, state_next;
    logic [BIN_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic                  issue_reg, issue_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [BIN_BITS-1:0]   wr_idx_reg, wr_idx_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS:0]   acc_sum;
    logic [COUNT_BITS-1:0] acc_sat;

    // Saturating accumulation of the count that has just been read.
    assign acc_sum = {1'b0, acc_reg} + {1'b0, cnt_rd_data};
    assign acc_sat = acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];

    // Read one bin a cycle; write its running sum in the cycle after.
    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        issue_next   = issue_reg;
        wr_pend_next = wr_pend_reg;
        wr_idx_next  = wr_idx_reg;
        acc_next     = acc_reg;
        case (state_reg)
            BLD_IDLE:
            begin
                if (start)
                begin
                    state_next   = BLD_RUN;
                    rd_idx_next  = '0;
                    issue_next   = 1'b1;
                    wr_pend_next = 1'b0;
                    acc_next     = '0;
                end
            end
            BLD_RUN:
            begin
                wr_pend_next = issue_reg;
                if (issue_reg)
                begin
                    wr_idx_next = rd_idx_reg;
                    if (rd_idx_reg == LAST_BIN)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + BIN_BITS'(1);
                    end
                end
                if (wr_pend_reg)
                begin
                    acc_next = acc_sat;
                    if (wr_idx_reg == LAST_BIN)
                    begin
                        state_next = BLD_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BLD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BLD_IDLE;
            issue_reg   <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        acc_reg    <= acc_next;
    end

    assign busy = (state_reg == BLD_RUN);

    // Store accesses issued by the walk.
    always_comb
    begin
        cnt_req         = '0;
        cnt_req.rd_en   = busy && issue_reg;
        cnt_req.rd_addr = rd_idx_reg;
        sum_req         = '0;
        sum_req.wr_en   = busy && wr_pend_reg;
        sum_req.wr_addr = wr_idx_reg;
        sum_req.wr_data = acc_sat;
    end

endmodule

// File: design/gray_histogram_cumulative.sv
// Top level of the grey-level histogram with cumulative sums.
// Each input transaction carries one operation. Clear, count and read
// pass through a two-stage pipeline around the bin-count memory (read
// issued on acceptance, modify and write in the cycle after, with the
// value just written forwarded to a following access of the same bin), so
// they are taken at one per clock; a read waits only while the output
// register still holds a result that has not been taken. A clear drops
// the per-entry valid bits in both stores at once, with no sweep. A build
// walks the count memory one bin per cycle, feeding the running-sum
// memory; s_tready is low while it runs. Only a read produces an output
// transaction. Running sums change only on a build or a clear, so a read
// after further counts returns the sums of the last build. Counts and
// sums saturate at all ones; out-of-range pixels are ignored and
// out-of-range reads return zeros.
module gray_histogram_cumulative
    import ghc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // Fields from bit 0: operation[1:0], pixel_value[9:2], bin_index[17:10], zero fill.
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0: bin_count, cumulative_count.
    output logic [OUT_BITS-1:0] m_tdata
);

    op_t                   in_op;
    logic [FIELD_BITS-1:0] in_pixel;
    logic [FIELD_BITS-1:0] in_bin;
    logic                  accept;
    logic [BIN_BITS-1:0]   new_addr;
    logic                  new_in_range;

    logic                  s2_valid_reg, s2_valid_next;
    op_t                   s2_op_reg;
    logic [BIN_BITS-1:0]   s2_addr_reg;
    logic                  s2_in_range_reg;
    logic                  s2_prev_clr_reg;
    logic                  s2_fwd_hit_reg;
    logic [COUNT_BITS-1:0] s2_fwd_data_reg;
    logic                  s2_advance;

    logic [COUNT_BITS-1:0] cnt_rd_data;
    logic [COUNT_BITS-1:0] sum_rd_data;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] sum_cur;
    logic                  cnt_wr_en;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic                  clr;

    logic                  build_start;
    logic                  build_busy;
    store_req_t            bld_cnt_req;
    store_req_t            bld_sum_req;
    store_req_t            cnt_req;
    store_req_t            sum_req;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0]   m_data_reg;
    logic                  out_free;

    // Input field unpacking.
    assign in_op        = op_t'(s_tdata[1:0]);
    assign in_pixel     = s_tdata[9:2];
    assign in_bin       = s_tdata[17:10];
    assign accept       = s_tvalid && s_tready;
    assign new_addr     = (in_op == OP_COUNT) ? bin_addr(in_pixel) : bin_addr(in_bin);
    assign new_in_range = (in_op == OP_COUNT) ? bin_in_range(in_pixel) : bin_in_range(in_bin);

    // Current bin values seen by the second stage, after forwarding.
    assign cnt_cur = s2_fwd_hit_reg  ? s2_fwd_data_reg :
                     s2_prev_clr_reg ? '0 : cnt_rd_data;
    assign sum_cur = s2_prev_clr_reg ? '0 : sum_rd_data;

    // Pipeline flow control.
    assign out_free    = !m_valid_reg || m_tready;
    assign s2_advance  = s2_valid_reg && ((s2_op_reg != OP_READ) || out_free);
    assign s_tready    = !build_busy &&
                         (!s2_valid_reg || (s2_advance && (s2_op_reg != OP_BUILD)));
    assign build_start = s2_valid_reg && (s2_op_reg == OP_BUILD);

    // Second-stage write-back of a counted pixel and clearing of both stores.
    assign cnt_wr_en   = s2_advance && (s2_op_reg == OP_COUNT) && s2_in_range_reg;
    assign cnt_wr_data = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    assign clr         = s2_advance && (s2_op_reg == OP_CLEAR);

    // Store port selection between the pipeline and the build walk.
    always_comb
    begin
        if (build_busy)
        begin
            cnt_req = bld_cnt_req;
        end
        else
        begin
            cnt_req         = '0;
            cnt_req.rd_en   = accept;
            cnt_req.rd_addr = new_addr;
            cnt_req.wr_en   = cnt_wr_en;
            cnt_req.wr_addr = s2_addr_reg;
            cnt_req.wr_data = cnt_wr_data;
            cnt_req.clr     = clr;
        end
        sum_req         = bld_sum_req;
        sum_req.clr     = clr;
        sum_req.rd_en   = accept;
        sum_req.rd_addr = new_addr;
    end

    ghc_store u_cnt_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cnt_req),
        .rd_data (cnt_rd_data)
    );

    ghc_store u_sum_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sum_req),
        .rd_data (sum_rd_data)
    );

    ghc_build u_build
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (build_start),
        .cnt_rd_data (cnt_rd_data),
        .busy        (build_busy),
        .cnt_req     (bld_cnt_req),
        .sum_req     (bld_sum_req)
    );

    // Second-stage occupancy and output register control.
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (accept)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_advance)
        begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s2_advance && (s2_op_reg == OP_READ))
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Second-stage payload, forwarding of a count written in the cycle of the next access's read, and output data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_op_reg       <= in_op;
            s2_addr_reg     <= new_addr;
            s2_in_range_reg <= new_in_range;
            s2_prev_clr_reg <= clr;
            s2_fwd_hit_reg  <= cnt_wr_en && (s2_addr_reg == new_addr);
            s2_fwd_data_reg <= cnt_wr_data;
        end
        if (s2_advance && (s2_op_reg == OP_READ))
        begin
            m_data_reg <= OUT_BITS'({s2_in_range_reg ? sum_cur : '0,
                                     s2_in_range_reg ? cnt_cur : '0});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: design/ghc_checker.sv
// Port-level assertions for the histogram block and the bind that attaches them.
module ghc_checker
    import ghc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [IN_BITS-1:0]  s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    logic in_acc;

    assign in_acc = s_tvalid && s_tready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction withdrawn while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // A build keeps the input side closed in the cycle that follows it.
    a_build_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_tdata[1:0] == OP_BUILD) |=> !s_tready)
        else $error("input accepted right after a build");

    // An accepted read is followed by a result on offer at the output.
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_tdata[1:0] == OP_READ) |-> ##2 m_tvalid)
        else $error("read produced no output transaction");

endmodule

bind gray_histogram_cumulative ghc_checker u_ghc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
